// File: hw/rtl/dsk_pkg.sv
package dsk_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TRACK_BITS_DEF  = 16;

  // Fixed field widths
  localparam int SEEK_W      = 22;
  localparam int SERVED_W    = 5;
  localparam int STATUS_W    = 2;
  localparam int POLICY_W    = 3;
  localparam int CYL_W       = 17;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYLINDERS = 1'd1;

  // Operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Policies
  localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_SCAN  = 3'd2;
  localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_CSCAN = 3'd4;
  localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

  // Command to the head move unit
  typedef struct packed {
    logic clear;
    logic step;
  } mv_cmd_t;

endpackage

// File: hw/rtl/dsk_move_unit.sv
module dsk_move_unit #(
  parameter int HEAD_W = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dsk_pkg::mv_cmd_t           cmd,
  input  logic [HEAD_W-1:0]          start,
  input  logic [HEAD_W-1:0]          target,
  output logic [HEAD_W-1:0]          head,
  output logic [HEAD_W-1:0]          gap,
  output logic                       above,
  output logic [dsk_pkg::SEEK_W-1:0] acc,
  output logic                       sat
);
  import dsk_pkg::*;

  localparam int SUM_W = ((SEEK_W > HEAD_W) ? SEEK_W : HEAD_W) + 1;

  logic [SUM_W-1:0] sum;

  // Distance from the head to the target, shared by search and move
  assign above = target > head;
  assign gap   = above ? (target - head) : (head - target);
  assign sum   = SUM_W'(acc) + SUM_W'(gap);

  // Move the head and accumulate travel, clamping at the maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      acc  <= '0;
      sat  <= 1'b0;
    end else if (cmd.clear) begin
      head <= start;
      acc  <= '0;
      sat  <= 1'b0;
    end else if (cmd.step) begin
      head <= target;
      if (sum > SUM_W'(SEEK_MAX)) begin
        acc <= SEEK_MAX;
        sat <= 1'b1;
      end else begin
        acc <= sum[SEEK_W-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/disk_request_seek_scheduler_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | operation, request_track, start_head
// out     | output    | out_valid / out_ready| total_seek, served_count, status
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A run walks the queue: FCFS moves to each request in order, SSTF scans for
// the nearest unserved request before each move, and sweep policies scan for
// bounds, then sweep. The single head move unit subtracts and accumulates.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register and the run stalls at its end while it is unread.
// Synchronous reset clears the queue count, flags and the output valid.
module disk_request_seek_scheduler_unit #(
  parameter int QUEUE_DEPTH = dsk_pkg::QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = dsk_pkg::TRACK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [TRACK_BITS-1:0]         request_track,
  input  logic [TRACK_BITS-1:0]         start_head,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsk_pkg::SEEK_W-1:0]    total_seek,
  output logic [dsk_pkg::SERVED_W-1:0]  served_count,
  output logic [dsk_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsk_pkg::CYL_W-1:0]     cfg_data
);
  import dsk_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (TRACK_BITS > CYL_W) ? TRACK_BITS : CYL_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_FCFS  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]             state;
  logic [POLICY_W-1:0]    policy;
  logic [CYL_W-1:0]       cyl_count;
  logic [TRACK_BITS-1:0]  store [QUEUE_DEPTH];
  logic [CW-1:0]          count;
  logic                   dropped;
  logic [QUEUE_DEPTH-1:0] marks;
  logic [IW-1:0]          idx;
  logic [CW-1:0]          rnd;
  logic [2:0]             mstep;
  logic                   found;
  logic [IW-1:0]          best;
  logic [HW-1:0]          bestd;
  logic                   any_a, any_b;
  logic [HW-1:0]          hi_a, max_b, min_b;

  logic                   in_fire, is_sstf, is_sweep, last;
  logic [HW-1:0]          entry, top, sweep_tgt, target, head, gap;
  logic                   sweep_ok, above, sat;
  logic [SEEK_W-1:0]      acc;
  mv_cmd_t                cmd;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign is_sstf   = (policy == POL_SSTF);
  assign is_sweep  = (policy == POL_SCAN) || (policy == POL_LOOK) ||
                     (policy == POL_CSCAN) || (policy == POL_CLOOK);
  assign last      = (CW'(CW'(idx) + CW'(1)) == count);
  assign entry     = HW'(store[idx]);
  assign top       = (cyl_count == '0) ? '0 : HW'(cyl_count - CYL_W'(1));

  // Pick the next sweep target and whether that step moves
  always_comb begin
    sweep_tgt = '0;
    sweep_ok  = 1'b0;
    case (mstep)
      3'd0: begin
        sweep_tgt = hi_a;
        sweep_ok  = any_a;
      end
      3'd1: begin
        sweep_tgt = top;
        sweep_ok  = (policy == POL_SCAN) || (policy == POL_CSCAN);
      end
      3'd2: begin
        sweep_tgt = (policy == POL_CSCAN) ? '0 : max_b;
        sweep_ok  = (policy == POL_CSCAN) ||
                    (any_b && ((policy == POL_SCAN) || (policy == POL_LOOK)));
      end
      3'd3: begin
        sweep_tgt = min_b;
        sweep_ok  = any_b;
      end
      3'd4: begin
        sweep_tgt = max_b;
        sweep_ok  = any_b && ((policy == POL_CSCAN) || (policy == POL_CLOOK));
      end
      default: begin
        sweep_tgt = '0;
        sweep_ok  = 1'b0;
      end
    endcase
  end

  // Steer the move unit
  always_comb begin
    target    = entry;
    cmd.clear = in_fire && (operation == OP_RUN);
    cmd.step  = 1'b0;
    case (state)
      S_SWEEP: begin
        target   = sweep_tgt;
        cmd.step = sweep_ok;
      end
      S_PICK: begin
        target   = HW'(store[best]);
        cmd.step = 1'b1;
      end
      S_FCFS:  cmd.step = 1'b1;
      default: cmd.step = 1'b0;
    endcase
  end

  dsk_move_unit #(
    .HEAD_W (HW)
  ) u_move (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .start  (HW'(start_head)),
    .target (target),
    .head   (head),
    .gap    (gap),
    .above  (above),
    .acc    (acc),
    .sat    (sat)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_FCFS;
      cyl_count <= CYL_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:    policy    <= cfg_data[POLICY_W-1:0];
        REG_CYLINDERS: cyl_count <= cfg_data;
        default:       policy    <= policy;
      endcase
    end
  end

  // Request queue
  always_ff @(posedge clk) begin
    if (in_fire && (operation == OP_LOAD) && (count < CW'(QUEUE_DEPTH))) begin
      store[count[IW-1:0]] <= request_track;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      marks     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      rnd       <= '0;
      mstep     <= '0;
      found     <= 1'b0;
      any_a     <= 1'b0;
      any_b     <= 1'b0;
    end else begin
      // drop the taken word unless a new one is posted this cycle
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (operation == OP_LOAD) begin
              if (count < CW'(QUEUE_DEPTH)) begin
                count <= CW'(count + CW'(1));
              end else begin
                dropped <= 1'b1;
              end
            end else begin
              idx   <= '0;
              rnd   <= '0;
              mstep <= '0;
              found <= 1'b0;
              any_a <= 1'b0;
              any_b <= 1'b0;
              marks <= '0;
              if (count == '0) begin
                state <= S_FIN;
              end else if (is_sstf || is_sweep) begin
                state <= S_SCAN;
              end else begin
                state <= S_FCFS;
              end
            end
          end
        end
        S_SCAN: begin
          // gather the nearest unserved entry, or the sweep bounds
          if (is_sstf) begin
            if (!marks[idx] && (!found || (gap < bestd))) begin
              found <= 1'b1;
              bestd <= gap;
              best  <= idx;
            end
          end else if (above) begin
            any_a <= 1'b1;
            if (!any_a || (entry > hi_a)) hi_a <= entry;
          end else begin
            any_b <= 1'b1;
            if (!any_b || (entry > max_b)) max_b <= entry;
            if (!any_b || (entry < min_b)) min_b <= entry;
          end
          if (last) begin
            idx   <= '0;
            state <= is_sstf ? S_PICK : S_SWEEP;
          end else begin
            idx <= IW'(idx + IW'(1));
          end
        end
        S_PICK: begin
          marks[best] <= 1'b1;
          rnd         <= CW'(rnd + CW'(1));
          found       <= 1'b0;
          state       <= (CW'(rnd + CW'(1)) == count) ? S_FIN : S_SCAN;
        end
        S_FCFS: begin
          if (last) begin
            state <= S_FIN;
          end else begin
            idx <= IW'(idx + IW'(1));
          end
        end
        S_SWEEP: begin
          if (mstep == 3'd4) begin
            state <= S_FIN;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        S_FIN: begin
          // post the word once the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            total_seek   <= acc;
            served_count <= SERVED_W'(count);
            if (count == '0)  status <= ST_EMPTY;
            else if (sat)     status <= ST_SAT;
            else if (dropped) status <= ST_DROPPED;
            else              status <= ST_OK;
            count   <= '0;
            dropped <= 1'b0;
            marks   <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/dsk_checker.sv
module dsk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dsk_pkg::SEEK_W-1:0]    total_seek,
  input logic [dsk_pkg::SERVED_W-1:0]  served_count,
  input logic [dsk_pkg::STATUS_W-1:0]  status
);
  import dsk_pkg::*;

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_seek) && $stable(status))
    else $error("result word changed while stalled");

  // Empty queue reports nothing served and no travel
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (total_seek == '0) && (served_count == '0))
    else $error("empty run reported travel");

  // A non-empty run served something
  a_served: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_EMPTY) |-> (served_count != '0))
    else $error("run result with zero served");

  // A load never produces a result
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_LOAD) |=> !$rose(out_valid))
    else $error("result after a load");

  // Reset drops the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind disk_request_seek_scheduler_unit dsk_checker u_dsk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .operation    (operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .total_seek   (total_seek),
  .served_count (served_count),
  .status       (status)
);
